@@ rtl/frs_pkg.sv @@
`timescale 1ns / 1ps

package frs_pkg;

  // Sizing of the datapath and the coefficient store.
  localparam int FRAC_BITS   = 12;
  localparam int PHASE_BITS  = 5;
  localparam int MAX_TAPS    = 24;
  localparam int SAMPLE_BITS = 24;
  localparam int PH_DIFF     = FRAC_BITS - PHASE_BITS;
  localparam int COEF_BITS   = 18;
  localparam int COEF_DEPTH  = (1 << PHASE_BITS) * 4 * MAX_TAPS;
  localparam int COEF_AW     = 12;
  localparam int TAP_W       = $clog2(MAX_TAPS + 1);
  localparam int HIST_AW     = $clog2(MAX_TAPS);
  localparam int STEP_BITS   = 16;
  localparam int SF_BITS     = 16;
  localparam int TAPS_BITS   = 5;
  localparam int MODE_BITS   = 2;
  localparam int START_BITS  = 12;
  localparam int SUM_W       = STEP_BITS + 1;
  localparam int RUN_CAP     = 64;
  localparam int RUN_W       = $clog2(RUN_CAP);
  localparam int CFG_IW      = 3;
  localparam int CFG_DW      = 16;

  // Interpolation modes.
  typedef enum logic [MODE_BITS-1:0] {
    MODE_POINT  = 2'd0,
    MODE_LINEAR = 2'd1,
    MODE_FAST   = 2'd2,
    MODE_FULL   = 2'd3
  } mode_t;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] CFG_MODE  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_STEP  = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_TAPS  = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_SCALE = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_START = 3'd4;

  // Input transaction kinds.
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_COEF = 1'b1;

  // Coefficient kinds within one phase row.
  typedef enum logic [1:0] {
    KIND_BASE  = 2'd0,
    KIND_PHASE = 2'd1,
    KIND_SCALE = 2'd2,
    KIND_SCPH  = 2'd3
  } coef_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_LIN,
    ST_FETCH,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // Travels with every coefficient read towards the tap datapath.
  typedef struct packed {
    logic                          valid;
    coef_kind_t                    kind;
    logic                          last;
    logic signed [SAMPLE_BITS-1:0] sample;
  } tap_tag_t;

  // Number of history samples one output uses.
  function automatic logic [TAP_W-1:0] window_len(mode_t mode, logic [TAPS_BITS-1:0] taps);
    logic [TAP_W-1:0] t;
    t = TAP_W'(taps);
    if (taps < TAPS_BITS'(4)) t = TAP_W'(4);
    else if (TAP_W'(taps) > TAP_W'(MAX_TAPS)) t = TAP_W'(MAX_TAPS);
    case (mode)
      MODE_POINT:  window_len = TAP_W'(1);
      MODE_LINEAR: window_len = TAP_W'(2);
      default:     window_len = t;
    endcase
  endfunction

  // Clamp a wide signed value to the sample range.
  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (x > hi) sat_sample = SAMPLE_BITS'(hi);
    else if (x < lo) sat_sample = SAMPLE_BITS'(lo);
    else sat_sample = SAMPLE_BITS'(x);
  endfunction

endpackage

@@ rtl/frs_coef_ram.sv @@
`timescale 1ns / 1ps

module frs_coef_ram (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [frs_pkg::COEF_AW-1:0]          waddr,
  input  logic signed [frs_pkg::COEF_BITS-1:0] wdata,
  input  logic [frs_pkg::COEF_AW-1:0]          raddr,
  output logic signed [frs_pkg::COEF_BITS-1:0] rdata
);

  logic signed [frs_pkg::COEF_BITS-1:0] mem [frs_pkg::COEF_DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/frs_tap_mac.sv @@
`timescale 1ns / 1ps

module frs_tap_mac (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   clr,
  input  frs_pkg::tap_tag_t                      tag,
  input  logic signed [frs_pkg::COEF_BITS-1:0]   rdata,
  input  logic [frs_pkg::SF_BITS-1:0]            sf,
  input  logic [frs_pkg::PH_DIFF-1:0]            pf,
  output logic                                   done,
  output logic signed [frs_pkg::SAMPLE_BITS-1:0] result
);

  localparam int BW = frs_pkg::COEF_BITS + frs_pkg::SF_BITS + 2;
  localparam int PW = BW + frs_pkg::PH_DIFF + 1;
  localparam int CW = frs_pkg::COEF_BITS + 4;
  localparam int MW = CW + frs_pkg::SAMPLE_BITS;
  localparam int AW = MW + frs_pkg::TAP_W;

  frs_pkg::tap_tag_t tag_d_r;
  logic signed [BW-1:0] base_r, slope_r, sf_prod;
  logic s1_valid_r, s1_last_r, s2_valid_r, s2_last_r, s3_valid_r, s3_last_r;
  logic s4_valid_r, s4_last_r, done_r;
  logic signed [BW-1:0] s1_base_r, s1_slope_r, s2_base_r;
  logic signed [frs_pkg::SAMPLE_BITS-1:0] s1_smp_r, s2_smp_r, s3_smp_r;
  logic signed [PW-1:0] s2_prod_r, c32;
  logic signed [CW-1:0] s3_coef_r;
  logic signed [MW-1:0] s4_mul_r;
  logic signed [AW-1:0] acc_r, acc_rnd;

  // Scale factor times the word just read.
  assign sf_prod = BW'($signed({1'b0, sf})) * BW'(rdata);

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      s2_valid_r    <= 1'b0;
      s3_valid_r    <= 1'b0;
      s4_valid_r    <= 1'b0;
      done_r        <= 1'b0;
    end else begin
      s1_valid_r    <= tag_d_r.valid && (tag_d_r.kind == frs_pkg::KIND_SCPH);
      s2_valid_r    <= s1_valid_r;
      s3_valid_r    <= s2_valid_r;
      s4_valid_r    <= s3_valid_r;
      done_r        <= s4_valid_r && s4_last_r;
    end
  end

  // Gather the four words of one tap into base and slope.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_d_r.valid <= 1'b0;
    end else begin
      tag_d_r.valid <= tag.valid;
    end
    tag_d_r.kind   <= tag.kind;
    tag_d_r.last   <= tag.last;
    tag_d_r.sample <= tag.sample;
    if (tag_d_r.valid) begin
      case (tag_d_r.kind)
        frs_pkg::KIND_BASE:  base_r  <= BW'(rdata) <<< 16;
        frs_pkg::KIND_PHASE: slope_r <= BW'(rdata) <<< 16;
        frs_pkg::KIND_SCALE: base_r  <= base_r + sf_prod;
        default: begin
          s1_base_r  <= base_r;
          s1_slope_r <= slope_r + sf_prod;
          s1_smp_r   <= tag_d_r.sample;
          s1_last_r  <= tag_d_r.last;
        end
      endcase
    end
  end

  // Slope times the phase fraction, then the rounded coefficient.
  assign c32 = PW'(s2_base_r) + (s2_prod_r >>> frs_pkg::PH_DIFF);

  always_ff @(posedge clk) begin
    s2_prod_r <= PW'(s1_slope_r) * PW'($signed({1'b0, pf}));
    s2_base_r <= s1_base_r;
    s2_smp_r  <= s1_smp_r;
    s2_last_r <= s1_last_r;
    s3_coef_r <= CW'((c32 + (PW'(1) <<< 15)) >>> 16);
    s3_smp_r  <= s2_smp_r;
    s3_last_r <= s2_last_r;
    s4_mul_r  <= MW'(s3_coef_r) * MW'(s3_smp_r);
    s4_last_r <= s3_last_r;
  end

  // Accumulator over the taps of one output.
  always_ff @(posedge clk) begin
    if (clr) begin
      acc_r <= '0;
    end else if (s4_valid_r) begin
      acc_r <= acc_r + AW'(s4_mul_r);
    end
  end

  assign acc_rnd = (acc_r + (AW'(1) <<< 15)) >>> 16;
  assign result  = frs_pkg::sat_sample(64'(acc_rnd));
  assign done    = done_r;

endmodule

@@ rtl/fractional_phase_resampler.sv @@
`timescale 1ns / 1ps
// While idle, the block accepts a coefficient write or skipped push every cycle; a push that produces outputs
// occupies the block until its last output is placed in the output register.
// Per output, point mode steps through setup and emit, linear through setup, interpolation and emit;
// sinc is bound by the single coefficient memory read port, which fetches four words for every tap.
// Synchronous active-low reset clears control and configuration registers, history and phase;
// the coefficient memory is not cleared.

module fractional_phase_resampler (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_action,
  input  logic signed [frs_pkg::SAMPLE_BITS-1:0] in_sample_in,
  input  logic [frs_pkg::COEF_AW-1:0]            in_coef_index,
  input  logic signed [frs_pkg::COEF_BITS-1:0]   in_coef_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [frs_pkg::SAMPLE_BITS-1:0] out_sample_out,
  output logic                                   out_last_of_run,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [frs_pkg::CFG_IW-1:0]             cfg_index,
  input  logic [frs_pkg::CFG_DW-1:0]             cfg_data
);

  localparam int LPW = frs_pkg::SAMPLE_BITS + frs_pkg::FRAC_BITS + 2;

  frs_pkg::state_t state_r, state_nxt;
  frs_pkg::mode_t mode_r, mode_nxt, cfg_mode;
  logic [frs_pkg::STEP_BITS-1:0] step_r, step_nxt;
  logic [frs_pkg::TAPS_BITS-1:0] taps_r, taps_nxt, cfg_taps;
  logic [frs_pkg::SF_BITS-1:0] sf_r, sf_nxt;
  logic [frs_pkg::START_BITS-1:0] start_r, start_nxt;
  logic [frs_pkg::FRAC_BITS-1:0] phase_r, phase_nxt;
  logic [frs_pkg::TAP_W-1:0] skip_r, skip_nxt, t, tap_r, tap_nxt;
  logic [frs_pkg::RUN_W-1:0] n_r, n_nxt;
  logic [frs_pkg::COEF_AW-1:0] addr_r, addr_nxt;
  frs_pkg::coef_kind_t kind_r, kind_nxt;
  logic [frs_pkg::HIST_AW-1:0] widx_r, widx_nxt;
  logic signed [LPW-1:0] lin_prod_r, lin_prod_nxt;
  logic signed [frs_pkg::SAMPLE_BITS-1:0] res_r, res_nxt, out_sample_r, out_sample_nxt;
  logic out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic signed [frs_pkg::SAMPLE_BITS-1:0] hist_r [frs_pkg::MAX_TAPS];
  logic in_fire, push_fire, cfg_fire, coef_we, mac_clr, mac_done, emit_last;
  logic [frs_pkg::SUM_W-1:0] phase_sum;
  logic [frs_pkg::SUM_W-frs_pkg::FRAC_BITS-1:0] adv;
  logic signed [frs_pkg::SAMPLE_BITS:0] lin_diff;
  logic signed [LPW-1:0] lin_sum;
  logic signed [frs_pkg::SAMPLE_BITS-1:0] mac_res;
  logic [frs_pkg::SF_BITS-1:0] mac_sf;
  logic signed [frs_pkg::COEF_BITS-1:0] rdata;
  frs_pkg::tap_tag_t tag;

  assign in_ready  = (state_r == frs_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign push_fire = in_fire && (in_action == frs_pkg::ACT_PUSH);
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign coef_we   = in_fire && (in_action == frs_pkg::ACT_COEF) &&
                     (in_coef_index < frs_pkg::COEF_AW'(frs_pkg::COEF_DEPTH));
  assign t         = frs_pkg::window_len(mode_r, taps_r);

  // Phase advance after each output.
  assign phase_sum = frs_pkg::SUM_W'(phase_r) + frs_pkg::SUM_W'(step_r);
  assign adv       = phase_sum[frs_pkg::SUM_W-1:frs_pkg::FRAC_BITS];
  assign emit_last = (adv != '0) || (n_r == frs_pkg::RUN_W'(frs_pkg::RUN_CAP - 1));

  // Linear interpolation terms.
  assign lin_diff = (frs_pkg::SAMPLE_BITS+1)'(hist_r[frs_pkg::MAX_TAPS-1]) -
                    (frs_pkg::SAMPLE_BITS+1)'(hist_r[frs_pkg::MAX_TAPS-2]);
  assign lin_sum  = LPW'(hist_r[frs_pkg::MAX_TAPS-2]) +
                    ((lin_prod_r + (LPW'(1) <<< (frs_pkg::FRAC_BITS - 1))) >>>
                     frs_pkg::FRAC_BITS);

  // Register values a configuration transaction leaves behind.
  assign cfg_mode = (cfg_index == frs_pkg::CFG_MODE) ?
                    frs_pkg::mode_t'(cfg_data[frs_pkg::MODE_BITS-1:0]) : mode_r;
  assign cfg_taps = (cfg_index == frs_pkg::CFG_TAPS) ? cfg_data[frs_pkg::TAPS_BITS-1:0] : taps_r;

  // Tag for the coefficient read issued this cycle.
  assign tag.valid  = (state_r == frs_pkg::ST_FETCH);
  assign tag.kind   = kind_r;
  assign tag.last   = (tap_r == t - frs_pkg::TAP_W'(1));
  assign tag.sample = hist_r[widx_r];
  assign mac_sf     = (mode_r == frs_pkg::MODE_FULL) ? sf_r : '0;

  frs_coef_ram u_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (in_coef_index),
    .wdata (in_coef_value),
    .raddr (addr_r),
    .rdata (rdata)
  );

  frs_tap_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .clr    (mac_clr),
    .tag    (tag),
    .rdata  (rdata),
    .sf     (mac_sf),
    .pf     (phase_r[frs_pkg::PH_DIFF-1:0]),
    .done   (mac_done),
    .result (mac_res)
  );

  // Sequencer: next state and datapath control.
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    step_nxt       = step_r;
    taps_nxt       = taps_r;
    sf_nxt         = sf_r;
    start_nxt      = start_r;
    phase_nxt      = phase_r;
    skip_nxt       = skip_r;
    n_nxt          = n_r;
    addr_nxt       = addr_r;
    kind_nxt       = kind_r;
    tap_nxt        = tap_r;
    widx_nxt       = widx_r;
    lin_prod_nxt   = lin_prod_r;
    res_nxt        = res_r;
    out_sample_nxt = out_sample_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    mac_clr        = 1'b0;
    case (state_r)
      frs_pkg::ST_IDLE: begin
        if (push_fire) begin
          if (skip_r != '0) begin
            skip_nxt = skip_r - frs_pkg::TAP_W'(1);
          end else begin
            n_nxt     = '0;
            state_nxt = frs_pkg::ST_SETUP;
          end
        end
      end
      frs_pkg::ST_SETUP: begin
        case (mode_r)
          frs_pkg::MODE_POINT: begin
            res_nxt   = hist_r[frs_pkg::MAX_TAPS-1];
            state_nxt = frs_pkg::ST_EMIT;
          end
          frs_pkg::MODE_LINEAR: begin
            lin_prod_nxt = LPW'(lin_diff) * LPW'($signed({1'b0, phase_r}));
            state_nxt    = frs_pkg::ST_LIN;
          end
          default: begin
            addr_nxt  = frs_pkg::COEF_AW'(t) *
                        frs_pkg::COEF_AW'(phase_r[frs_pkg::FRAC_BITS-1:frs_pkg::PH_DIFF]) *
                        frs_pkg::COEF_AW'(4);
            kind_nxt  = frs_pkg::KIND_BASE;
            tap_nxt   = '0;
            widx_nxt  = frs_pkg::HIST_AW'(frs_pkg::TAP_W'(frs_pkg::MAX_TAPS) - t);
            mac_clr   = 1'b1;
            state_nxt = frs_pkg::ST_FETCH;
          end
        endcase
      end
      frs_pkg::ST_LIN: begin
        res_nxt   = frs_pkg::sat_sample(64'(lin_sum));
        state_nxt = frs_pkg::ST_EMIT;
      end
      frs_pkg::ST_FETCH: begin
        if (kind_r != frs_pkg::KIND_SCPH) begin
          addr_nxt = addr_r + frs_pkg::COEF_AW'(t);
          kind_nxt = frs_pkg::coef_kind_t'(kind_r + 2'd1);
        end else begin
          addr_nxt = addr_r - frs_pkg::COEF_AW'(t) * frs_pkg::COEF_AW'(3) +
                     frs_pkg::COEF_AW'(1);
          kind_nxt = frs_pkg::KIND_BASE;
          tap_nxt  = tap_r + frs_pkg::TAP_W'(1);
          widx_nxt = widx_r + frs_pkg::HIST_AW'(1);
          if (tap_r == t - frs_pkg::TAP_W'(1)) begin
            state_nxt = frs_pkg::ST_DRAIN;
          end
        end
      end
      frs_pkg::ST_DRAIN: begin
        if (mac_done) begin
          res_nxt   = mac_res;
          state_nxt = frs_pkg::ST_EMIT;
        end
      end
      frs_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = res_r;
          out_last_nxt   = emit_last;
          phase_nxt      = phase_sum[frs_pkg::FRAC_BITS-1:0];
          n_nxt          = n_r + frs_pkg::RUN_W'(1);
          if (adv != '0) begin
            skip_nxt = frs_pkg::TAP_W'(adv) - frs_pkg::TAP_W'(1);
          end
          state_nxt = emit_last ? frs_pkg::ST_IDLE : frs_pkg::ST_SETUP;
        end
      end
      default: state_nxt = frs_pkg::ST_IDLE;
    endcase

    // The user must send configuration transactions only while idle; the block does not enforce it.
    if (cfg_fire) begin
      case (cfg_index)
        frs_pkg::CFG_MODE:  mode_nxt  = cfg_mode;
        frs_pkg::CFG_STEP:  step_nxt  = cfg_data[frs_pkg::STEP_BITS-1:0];
        frs_pkg::CFG_TAPS:  taps_nxt  = cfg_taps;
        frs_pkg::CFG_SCALE: sf_nxt    = cfg_data[frs_pkg::SF_BITS-1:0];
        frs_pkg::CFG_START: start_nxt = cfg_data[frs_pkg::START_BITS-1:0];
        default: ;
      endcase
      if ((cfg_index == frs_pkg::CFG_MODE) || (cfg_index == frs_pkg::CFG_TAPS) ||
          (cfg_index == frs_pkg::CFG_START)) begin
        phase_nxt = frs_pkg::FRAC_BITS'(start_nxt);
        skip_nxt  = frs_pkg::window_len(cfg_mode, cfg_taps) - frs_pkg::TAP_W'(1);
      end
    end
  end

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= frs_pkg::ST_IDLE;
      mode_r      <= frs_pkg::MODE_LINEAR;
      step_r      <= frs_pkg::STEP_BITS'(4096);
      taps_r      <= frs_pkg::TAPS_BITS'(24);
      sf_r        <= '0;
      start_r     <= '0;
      phase_r     <= '0;
      skip_r      <= frs_pkg::window_len(frs_pkg::MODE_LINEAR, frs_pkg::TAPS_BITS'(24)) -
                     frs_pkg::TAP_W'(1);
      n_r         <= '0;
      out_valid_r <= 1'b0;
      kind_r      <= frs_pkg::KIND_BASE;
      tap_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      step_r      <= step_nxt;
      taps_r      <= taps_nxt;
      sf_r        <= sf_nxt;
      start_r     <= start_nxt;
      phase_r     <= phase_nxt;
      skip_r      <= skip_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
      kind_r      <= kind_nxt;
      tap_r       <= tap_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    widx_r       <= widx_nxt;
    lin_prod_r   <= lin_prod_nxt;
    res_r        <= res_nxt;
    out_sample_r <= out_sample_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Sample history, newest at the top.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < frs_pkg::MAX_TAPS; i++) begin
        hist_r[i] <= '0;
      end
    end else if (push_fire) begin
      for (int i = 0; i < frs_pkg::MAX_TAPS - 1; i++) begin
        hist_r[i] <= hist_r[i+1];
      end
      hist_r[frs_pkg::MAX_TAPS-1] <= in_sample_in;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sample_out  = out_sample_r;
  assign out_last_of_run = out_last_r;

  // The accumulator finishes only while the sequencer waits for it.
  a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> (state_r == frs_pkg::ST_DRAIN))
    else $error("tap accumulation finished outside drain");

  // Coefficient fetches stay inside the store and the window.
  a_fetch_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == frs_pkg::ST_FETCH) |->
      ((addr_r < frs_pkg::COEF_AW'(frs_pkg::COEF_DEPTH)) && (tap_r < t)))
    else $error("coefficient fetch out of range");

  // A new result appears only from the emit step.
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == frs_pkg::ST_EMIT))
    else $error("result presented outside emit");

  // The skip count never exceeds one less than the largest window, MAX_TAPS.
  a_skip_bound: assert property (@(posedge clk) disable iff (!rst_n)
    skip_r <= frs_pkg::TAP_W'(frs_pkg::MAX_TAPS - 1))
    else $error("skip count out of range");

endmodule

@@ bench/fractional_phase_resampler_tb.sv @@
`timescale 1ns / 1ps

module fractional_phase_resampler_tb;
  import frs_pkg::*;

  localparam int LIMIT_CYCLES = 4_000_000;
  localparam int SETTLE_CYCLES = 400;
  localparam int HOLD_CYCLES = 1500;

  typedef struct {
    logic                          act;
    logic signed [SAMPLE_BITS-1:0] smp;
    logic [COEF_AW-1:0]            idx;
    logic signed [COEF_BITS-1:0]   val;
  } feed_t;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] smp;
    logic                          last;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_action = ACT_PUSH;
  logic signed [SAMPLE_BITS-1:0] in_sample_in = '0;
  logic [COEF_AW-1:0] in_coef_index = '0;
  logic signed [COEF_BITS-1:0] in_coef_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_sample_out;
  logic out_last_of_run;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  fractional_phase_resampler dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_sample_in(in_sample_in), .in_coef_index(in_coef_index),
    .in_coef_value(in_coef_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_sample_out(out_sample_out),
    .out_last_of_run(out_last_of_run),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the block's registers and state.
  mode_t                         sh_mode;
  logic [STEP_BITS-1:0]          sh_step;
  logic [TAPS_BITS-1:0]          sh_taps;
  logic [SF_BITS-1:0]            sh_scale;
  logic [START_BITS-1:0]         sh_start;
  logic signed [SAMPLE_BITS-1:0] sh_hist [MAX_TAPS];
  logic signed [COEF_BITS-1:0]   sh_coef [COEF_DEPTH];
  logic [FRAC_BITS-1:0]          sh_phase;
  logic [TAPS_BITS-1:0]          sh_skip;

  feed_t    feed_q[$];
  outcome_t pending_outputs[$];
  int       errors = 0;
  int       cycle_count = 0;
  bit       quiet = 0;
  bit       hold_request = 0;
  bit       in_fire = 0;
  int       in_gap = 0;
  int       rx_gap = 0;
  int       hold_cnt = 0;

  function automatic int taps_used();
    int t;
    if (sh_mode == MODE_POINT) return 1;
    if (sh_mode == MODE_LINEAR) return 2;
    t = sh_taps;
    if (t < 4) t = 4;
    if (t > MAX_TAPS) t = MAX_TAPS;
    return t;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(longint x);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) x = hi;
    else if (x < lo) x = lo;
    return SAMPLE_BITS'(x);
  endfunction

  // One output value at phase f over the newest window of the history.
  function automatic logic signed [SAMPLE_BITS-1:0] interpolate(logic [FRAC_BITS-1:0] f);
    int t;
    int first;
    int pidx;
    int row;
    longint pf;
    longint sf;
    longint acc;
    longint base;
    longint slope;
    longint c32;
    longint v0;
    longint v1;
    t = taps_used();
    first = MAX_TAPS - t;
    v0 = sh_hist[first];
    if (sh_mode == MODE_POINT) return clamp_sample(v0);
    if (sh_mode == MODE_LINEAR) begin
      v1 = sh_hist[first + 1];
      return clamp_sample(v0 + (((v1 - v0) * longint'(f) + (1 << (FRAC_BITS - 1)))
                                >>> FRAC_BITS));
    end
    pidx = f >> PH_DIFF;
    pf = f & ((1 << PH_DIFF) - 1);
    sf = (sh_mode == MODE_FULL) ? longint'(sh_scale) : 0;
    row = t * pidx * 4;
    acc = 0;
    for (int j = 0; j < t; j++) begin
      base = longint'(sh_coef[row + j]) * 65536 + sf * longint'(sh_coef[row + 2 * t + j]);
      slope = longint'(sh_coef[row + t + j]) * 65536 + sf * longint'(sh_coef[row + 3 * t + j]);
      c32 = base + ((slope * pf) >>> PH_DIFF);
      acc += ((c32 + 32768) >>> 16) * longint'(sh_hist[first + j]);
    end
    return clamp_sample((acc + 32768) >>> 16);
  endfunction

  function automatic void reload_stream();
    sh_phase = FRAC_BITS'(sh_start);
    sh_skip = TAPS_BITS'(taps_used() - 1);
  endfunction

  function automatic void apply_register(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
    case (idx)
      CFG_MODE: begin
        sh_mode = mode_t'(data[MODE_BITS-1:0]);
        reload_stream();
      end
      CFG_STEP: sh_step = data[STEP_BITS-1:0];
      CFG_TAPS: begin
        sh_taps = data[TAPS_BITS-1:0];
        reload_stream();
      end
      CFG_SCALE: sh_scale = data[SF_BITS-1:0];
      CFG_START: begin
        sh_start = data[START_BITS-1:0];
        reload_stream();
      end
      default: ;
    endcase
  endfunction

  // Works out the outputs that one accepted input transaction causes.
  function automatic void resample_push(feed_t it);
    int n;
    int sum;
    outcome_t o;
    if (it.act == ACT_COEF) begin
      if (it.idx < COEF_DEPTH) sh_coef[it.idx] = it.val;
      return;
    end
    for (int j = 0; j < MAX_TAPS - 1; j++) sh_hist[j] = sh_hist[j + 1];
    sh_hist[MAX_TAPS - 1] = it.smp;
    if (sh_skip > 0) begin
      sh_skip--;
      return;
    end
    n = 0;
    forever begin
      o.smp = interpolate(sh_phase);
      o.last = 1'b0;
      pending_outputs.push_back(o);
      n++;
      sum = sh_phase + sh_step;
      sh_phase = sum[FRAC_BITS-1:0];
      if ((sum >> FRAC_BITS) > 0) begin
        sh_skip = TAPS_BITS'((sum >> FRAC_BITS) - 1);
        break;
      end
      if (n >= RUN_CAP) break;
    end
    pending_outputs[pending_outputs.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    errors++;
  endtask

  // Checking of output transactions and prediction of input transactions.
  always @(posedge clk) begin
    outcome_t want;
    feed_t it;
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (pending_outputs.size() == 0) begin
        report_mismatch("unexpected output", out_sample_out, 0);
      end else begin
        want = pending_outputs.pop_front();
        if (out_sample_out !== want.smp)
          report_mismatch("sample_out", out_sample_out, want.smp);
        if (out_last_of_run !== want.last)
          report_mismatch("last_of_run", out_last_of_run, want.last);
      end
    end
    if (rst_n && in_valid && in_ready) begin
      it.act = in_action;
      it.smp = in_sample_in;
      it.idx = in_coef_index;
      it.val = in_coef_value;
      resample_push(it);
      in_fire = 1;
    end
  end

  // Input driver, fed from the queue of waiting transactions.
  always @(negedge clk) begin
    feed_t it;
    if (!in_valid || in_fire) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (feed_q.size() > 0) begin
        it = feed_q.pop_front();
        in_action <= it.act;
        in_sample_in <= it.smp;
        in_coef_index <= it.idx;
        in_coef_value <= it.val;
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 16);
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_fire = 0;
  end

  // Output receiver with random stalls and an occasional long hold-off.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_cnt = HOLD_CYCLES;
      hold_request = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 9) == 0) rx_gap = $urandom_range(1, 16);
    end
  end

  task automatic add_sample(int s);
    feed_t it;
    it.act = ACT_PUSH;
    it.smp = SAMPLE_BITS'(s);
    it.idx = COEF_AW'($urandom);
    it.val = COEF_BITS'($urandom);
    feed_q.push_back(it);
  endtask

  task automatic add_coef(int idx, int val);
    feed_t it;
    it.act = ACT_COEF;
    it.smp = SAMPLE_BITS'($urandom);
    it.idx = COEF_AW'(idx);
    it.val = COEF_BITS'(val);
    feed_q.push_back(it);
  endtask

  // Waits until every transaction is sent and every output has arrived.
  task automatic wait_drained();
    while (feed_q.size() > 0 || in_valid || pending_outputs.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IW-1:0] idx, int data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DW'(data);
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, CFG_DW'(data));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_all(int mode, int step, int taps, int scale, int start);
    cfg_write(CFG_MODE, mode);
    cfg_write(CFG_STEP, step);
    cfg_write(CFG_TAPS, taps);
    cfg_write(CFG_SCALE, scale);
    cfg_write(CFG_START, start);
  endtask

  function automatic int edge_sample();
    case ($urandom_range(0, 4))
      0: return 8388607;
      1: return -8388608;
      2: return 0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int step;
    int npush;
    sh_mode = MODE_LINEAR;
    sh_step = 16'd4096;
    sh_taps = 5'd24;
    sh_scale = '0;
    sh_start = '0;
    for (int j = 0; j < MAX_TAPS; j++) sh_hist[j] = '0;
    for (int j = 0; j < COEF_DEPTH; j++) sh_coef[j] = '0;
    reload_stream();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Fill the whole coefficient store so that no read ever finds an unwritten word.
    for (int a = 0; a < COEF_DEPTH; a++) add_coef(a, $urandom_range(0, 8191) - 4096);

    // Reset settings: linear at unit step, with full-scale samples.
    add_sample(8388607);
    add_sample(-8388608);
    add_sample(8388607);
    add_sample(0);
    add_sample(-1);
    add_coef(4095, -131072);
    add_coef(3072, 131071);
    add_sample(-8388608);
    wait_drained();

    // Point mode with the largest step and phase; an unknown register index too.
    program_all(MODE_POINT, 65535, 31, 65535, 4095);
    cfg_write(3'd7, 16'hFFFF);
    for (int k = 0; k < 6; k++) add_sample(edge_sample());
    wait_drained();

    // Smallest step hits the run cap in linear mode.
    program_all(MODE_LINEAR, 64, 0, 0, 0);
    for (int k = 0; k < 3; k++) add_sample(edge_sample());
    wait_drained();

    // Fast sinc with the fewest taps, extreme coefficients at live addresses.
    program_all(MODE_FAST, 3000, 4, 0, 100);
    add_coef(0, 131071);
    add_coef(4, -131072);
    for (int k = 0; k < 8; k++) add_sample(edge_sample());
    wait_drained();

    // Full sinc, taps above the limit, largest scale: the receiver holds off
    // while pushes keep coming, so the block fills up.
    program_all(MODE_FULL, 2048, 30, 65535, 4095);
    hold_request = 1;
    for (int k = 0; k < 40; k++) add_sample(edge_sample());
    wait_drained();

    // Random phases; the last runs without idling.
    for (int ph = 0; ph < 12; ph++) begin
      quiet = (ph == 11);
      step = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 1023)
                                          : $urandom_range(1024, 65535);
      program_all($urandom_range(0, 3), step, $urandom_range(0, 31), $urandom,
                  $urandom_range(0, 4095));
      if ($urandom_range(0, 3) == 0) cfg_write(CFG_IW'($urandom_range(5, 7)), $urandom);
      npush = (step < 1024) ? 4 : 25;
      for (int k = 0; k < npush; k++) begin
        case ($urandom_range(0, 11))
          0: add_coef($urandom_range(0, COEF_DEPTH - 1), $urandom);
          1: add_coef($urandom_range(0, COEF_DEPTH - 1), $urandom_range(0, 8191) - 4096);
          2: add_coef($urandom_range(COEF_DEPTH, 4095), $urandom);
          3: add_sample(edge_sample());
          default: add_sample($urandom);
        endcase
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
